// ===== design/cdt_pkg.sv =====
// shared types, codes and the segment table for the countdown timer
// no dependencies
package cdt_pkg;

  localparam int SEC_W    = 10;
  localparam int PRE_W    = 16;
  localparam int ADC_W    = 10;
  localparam int SEG_W    = 7;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [PRE_W-1:0] TICK_RELOAD_RST = 16'd250;
  localparam logic [SEC_W-1:0] MAX_SECONDS_RST = 10'd100;

  // reciprocal of ten, exact for all 10-bit samples
  localparam logic [7:0] RECIP10     = 8'd205;
  localparam int         RECIP10_SHR = 11;

  typedef enum logic [1:0] {
    EV_TICK   = 2'd0,
    EV_START  = 2'd1,
    EV_STOP   = 2'd2,
    EV_SAMPLE = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TICK_RELOAD = 1'd0,
    REG_MAX_SECONDS = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SEC_W-1:0] seconds;
    logic             running;
    logic             alarm;
  } status_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
    logic [SEG_W-1:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== design/countdown_timer_seven_segment_unit.sv =====
// countdown timer top level: event handling, config registers, output skid stage
// depends on cdt_pkg and cdt_seg_dec
//
//   channel | ports                        | carries
//   --------+------------------------------+-------------------------------
//   in      | in_valid/in_stall            | in_func, in_adc_value
//   out     | out_valid/out_stall          | seconds, flags, three segments
//   cfg     | cfg_we/cfg_index/cfg_wdata   | tick_reload, max_seconds
//
// one event per clock while in_stall is low; the timer state updates at the accepting
// edge and the result is shown from the output register, or waits in the skid entry.
// a two-entry output (register plus skid) keeps input taking beats while one
// result waits; in_stall rises only when both entries are full.
// rst_n is synchronous and clears state, flags and valids.
module countdown_timer_seven_segment_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_func,
  input  logic [cdt_pkg::ADC_W-1:0]   in_adc_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cdt_pkg::SEC_W-1:0]   out_remaining_seconds,
  output logic                        out_is_running,
  output logic                        out_alarm_out,
  output logic [cdt_pkg::SEG_W-1:0]   out_hundreds_segments,
  output logic [cdt_pkg::SEG_W-1:0]   out_tens_segments,
  output logic [cdt_pkg::SEG_W-1:0]   out_ones_segments,
  input  logic                        cfg_we,
  input  logic [cdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cdt_pkg::CFG_W-1:0]   cfg_wdata
);
  import cdt_pkg::*;

  logic [PRE_W-1:0] tick_reload_r;
  logic [SEC_W-1:0] max_seconds_r;
  logic [PRE_W-1:0] pre_r, pre_nxt;
  status_t          st_r, st_nxt;
  status_t          out_r, skid_r;
  logic             out_v_r, skid_v_r;
  logic             in_acc, out_take;
  logic [SEC_W-1:0] sec_dec;
  logic [17:0]      adc_prod;
  logic [SEC_W-1:0] adc_div10;

  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_v_r && !out_stall;
  assign in_stall = skid_v_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_reload_r <= TICK_RELOAD_RST;
      max_seconds_r <= MAX_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICK_RELOAD: tick_reload_r <= cfg_wdata;
        REG_MAX_SECONDS: max_seconds_r <= cfg_wdata[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  assign adc_prod  = {8'd0, in_adc_value} * {10'd0, RECIP10};
  assign adc_div10 = {3'd0, adc_prod[17:RECIP10_SHR]};
  assign sec_dec   = (st_r.running && st_r.seconds != '0) ? st_r.seconds - 1'b1
                                                          : st_r.seconds;

  always_comb begin
    st_nxt  = st_r;
    pre_nxt = pre_r;
    unique case (event_t'(in_func))
      EV_TICK: begin
        if (pre_r == '0) begin
          pre_nxt        = tick_reload_r;
          st_nxt.seconds = sec_dec;
          if (st_r.running && sec_dec == '0) begin
            st_nxt.running = 1'b0;
            st_nxt.alarm   = 1'b1;
          end
        end else begin
          pre_nxt = pre_r - 1'b1;
        end
      end
      EV_START: st_nxt.running = 1'b1;
      EV_STOP: begin
        st_nxt.running = 1'b0;
        st_nxt.alarm   = 1'b0;
      end
      EV_SAMPLE: begin
        // samples only load while stopped
        if (!st_r.running) begin
          st_nxt.seconds = (adc_div10 > max_seconds_r) ? max_seconds_r : adc_div10;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= '0;
      pre_r <= TICK_RELOAD_RST;
    end else if (in_acc) begin
      st_r  <= st_nxt;
      pre_r <= pre_nxt;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (skid_v_r) begin
        if (out_take) begin
          out_v_r  <= 1'b1;
          skid_v_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_v_r || out_take) out_v_r  <= 1'b1;
        else                      skid_v_r <= 1'b1;
      end else if (out_take) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_take) out_r <= skid_r;
    end else if (in_acc) begin
      if (!out_v_r || out_take) out_r  <= st_nxt;
      else                      skid_r <= st_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_remaining_seconds = out_r.seconds;
  assign out_is_running        = out_r.running;
  assign out_alarm_out         = out_r.alarm;

  cdt_seg_dec u_seg (
    .seconds      (out_r.seconds),
    .hundreds_seg (out_hundreds_segments),
    .tens_seg     (out_tens_segments),
    .ones_seg     (out_ones_segments)
  );

endmodule

// ===== design/cdt_seg_dec.sv =====
// splits a seconds value into decimal digits and drives segment patterns
// depends on cdt_pkg
module cdt_seg_dec (
  input  logic [cdt_pkg::SEC_W-1:0] seconds,
  output logic [cdt_pkg::SEG_W-1:0] hundreds_seg,
  output logic [cdt_pkg::SEG_W-1:0] tens_seg,
  output logic [cdt_pkg::SEG_W-1:0] ones_seg
);
  import cdt_pkg::*;

  logic [3:0]  hund;
  logic [3:0]  tens;
  logic [3:0]  ones;
  logic [10:0] hund_x100;
  logic [6:0]  rem100;
  logic [6:0]  tens_x10;

  // independent compares against each hundred
  always_comb begin
    hund = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if ({1'b0, seconds} >= 11'(k * 100)) hund = 4'(k);
    end
  end

  assign hund_x100 = 11'(hund) * 11'd100;
  assign rem100    = 7'({1'b0, seconds} - hund_x100);

  always_comb begin
    tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem100 >= 7'(k * 10)) tens = 4'(k);
    end
  end

  assign tens_x10 = 7'(tens) * 7'd10;
  assign ones     = 4'(rem100 - tens_x10);

  assign hundreds_seg = seg_of(hund);
  assign tens_seg     = seg_of(tens);
  assign ones_seg     = seg_of(ones);

endmodule

// ===== design/cdt_checker.sv =====
// port-level checks for the countdown timer, bound to the top level
// depends on cdt_pkg
module cdt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [cdt_pkg::SEC_W-1:0]     out_remaining_seconds,
  input logic [cdt_pkg::SEG_W-1:0]     out_hundreds_segments
);
  import cdt_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_remaining_seconds))
    else $error("stalled result changed");

  // count never exceeds 102, the largest 10-bit sample divided by ten
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_remaining_seconds <= 10'd102)
    else $error("count out of range");

  // hundreds digit is zero or one
  a_hund_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hundreds_segments == 7'h3F || out_hundreds_segments == 7'h06))
    else $error("bad hundreds pattern");

  // reset empties the output side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not cleared by reset");

endmodule

bind countdown_timer_seven_segment_unit cdt_checker u_cdt_checker (.*);
